// ----- hdl/ulaq_pkg.sv -----
// ----------------------------------------------------------------------------
// ulaq_pkg
// Shared sizes, character codes, and controller/datapath link types for the
// line-buffered receive queue.
// ----------------------------------------------------------------------------
package ulaq_pkg;

    // Line buffer size (one byte kept for the terminator) and ring depth
    localparam int LINE_MAX    = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam int IDX_W  = $clog2(LINE_MAX);
    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [7:0]        t_byte;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_byte CH_CR          = 8'h0D;
    localparam t_byte CH_LF          = 8'h0A;
    localparam t_byte MIN_READ_LIMIT = 8'd2;

    // Which result beat to load into the output register
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_REFUSE,
        OUT_MID,
        OUT_END
    } t_out_sel;

    // Controller to datapath
    typedef struct packed {
        logic     rx_store;
        logic     rx_ovf;
        logic     line_clear;
        logic     copy_start;
        logic     copy_step;
        logic     commit;
        logic     rd_start;
        logic     rd_fetch;
        logic     rd_advance;
        t_out_sel out_sel;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_read;
        logic is_cr;
        logic is_lf;
        logic ovf;
        logic line_full;
        logic can_commit;
        logic read_ok;
        logic copy_last;
        logic byte_ok;
        logic pend_vld;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/ulaq_if.sv -----
// ----------------------------------------------------------------------------
// ulaq_in_if / ulaq_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface ulaq_in_if;
    logic                valid;
    logic                ready;
    logic                req_type;
    ulaq_pkg::t_byte     rx_byte;
    ulaq_pkg::t_byte     read_limit;

    modport source (output valid, output req_type, output rx_byte, output read_limit,
                    input ready);
    modport sink   (input valid, input req_type, input rx_byte, input read_limit,
                    output ready);
endinterface

interface ulaq_out_if;
    logic                valid;
    logic                ready;
    logic                has_line;
    logic                byte_valid;
    ulaq_pkg::t_byte     data_byte;
    logic                last;

    modport source (output valid, output has_line, output byte_valid, output data_byte,
                    output last, input ready);
    modport sink   (input valid, input has_line, input byte_valid, input data_byte,
                    input last, output ready);
endinterface

// ----- hdl/ulaq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ulaq_ctrl
// Sequencer: takes one request beat at a time, runs line commit copies and
// line read-outs by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module ulaq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ulaq_pkg::t_sts    i_sts,
    output ulaq_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_COPY   = 6'b000010,
        S_CDRAIN = 6'b000100,
        S_REFUSE = 6'b001000,
        S_RFETCH = 6'b010000,
        S_RCHECK = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.out_sel = ulaq_pkg::OUT_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.is_read) begin
                        if (i_sts.read_ok) begin
                            o_cmd.rd_start = 1'b1;
                            n_state        = S_RFETCH;
                        end else begin
                            n_state = S_REFUSE;
                        end
                    end else if (i_sts.is_cr) begin
                        n_state = S_IDLE;
                    end else if (i_sts.is_lf) begin
                        if (i_sts.can_commit) begin
                            o_cmd.copy_start = 1'b1;
                            n_state          = S_COPY;
                        end else begin
                            o_cmd.line_clear = 1'b1;
                        end
                    end else if (!i_sts.ovf) begin
                        if (i_sts.line_full) begin
                            o_cmd.rx_ovf = 1'b1;
                        end else begin
                            o_cmd.rx_store = 1'b1;
                        end
                    end
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = S_CDRAIN;
                end
            end
            S_CDRAIN: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            S_REFUSE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = ulaq_pkg::OUT_REFUSE;
                    n_state       = S_IDLE;
                end
            end
            S_RFETCH: begin
                o_cmd.rd_fetch = 1'b1;
                n_state        = S_RCHECK;
            end
            S_RCHECK: begin
                if (i_sts.byte_ok) begin
                    if (!i_sts.pend_vld) begin
                        o_cmd.rd_advance = 1'b1;
                        n_state          = S_RFETCH;
                    end else if (i_sts.out_free) begin
                        o_cmd.out_sel    = ulaq_pkg::OUT_MID;
                        o_cmd.rd_advance = 1'b1;
                        n_state          = S_RFETCH;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.out_sel = ulaq_pkg::OUT_END;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/ulaq_dp.sv -----
// ----------------------------------------------------------------------------
// ulaq_dp
// Datapath: line assembly buffer, slot memory, ring pointers, read-out
// lookahead and the output register.
// ----------------------------------------------------------------------------
module ulaq_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_type,
    input  ulaq_pkg::t_byte   i_rx_byte,
    input  ulaq_pkg::t_byte   i_read_limit,
    input  ulaq_pkg::t_cmd    i_cmd,
    output ulaq_pkg::t_sts    o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_has_line,
    output logic              o_byte_valid,
    output ulaq_pkg::t_byte   o_data_byte,
    output logic              o_last
);

    localparam int ADDR_W = ulaq_pkg::SLOT_W + ulaq_pkg::IDX_W;

    // Storage
    ulaq_pkg::t_byte cur_mem  [ulaq_pkg::LINE_MAX];
    ulaq_pkg::t_byte slot_mem [2**ADDR_W];
    ulaq_pkg::t_idx  r_slen   [ulaq_pkg::QUEUE_DEPTH];
    ulaq_pkg::t_byte r_cur_q;
    ulaq_pkg::t_byte r_slot_q;

    // Control state
    ulaq_pkg::t_idx  r_cur_len, n_cur_len;
    logic            r_ovf, n_ovf;
    ulaq_pkg::t_slot r_wslot, n_wslot;
    ulaq_pkg::t_slot r_rslot, n_rslot;
    ulaq_pkg::t_cnt  r_held, n_held;
    ulaq_pkg::t_idx  r_cidx, n_cidx;
    logic            r_cp_vld, n_cp_vld;
    ulaq_pkg::t_idx  r_cp_idx;
    ulaq_pkg::t_slot r_rbase, n_rbase;
    ulaq_pkg::t_idx  r_idx, n_idx;
    ulaq_pkg::t_idx  r_nlim, n_nlim;
    logic            r_pend_vld, n_pend_vld;
    ulaq_pkg::t_byte r_pend;
    logic            r_out_vld, n_out_vld;
    logic            r_out_has;
    logic            r_out_bv;
    ulaq_pkg::t_byte r_out_byte;
    logic            r_out_last;

    ulaq_pkg::t_byte lim_m1;
    ulaq_pkg::t_idx  len_sel;
    ulaq_pkg::t_idx  nlim_calc;
    logic            out_free;

    function automatic ulaq_pkg::t_slot slot_next(input ulaq_pkg::t_slot s);
        logic [31:0] s_inc;
        s_inc = 32'(s) + 32'd1;
        return (s_inc >= 32'(ulaq_pkg::QUEUE_DEPTH)) ? '0 : ulaq_pkg::t_slot'(s_inc);
    endfunction

    // Clip the popped line length to the destination size
    assign lim_m1    = i_read_limit - 8'd1;
    assign len_sel   = r_slen[r_rslot];
    assign nlim_calc = (lim_m1 < 8'(len_sel)) ? ulaq_pkg::t_idx'(lim_m1) : len_sel;
    assign out_free  = !r_out_vld || i_out_ready;

    // Status toward the controller
    always_comb begin
        o_sts.is_read    = i_req_type;
        o_sts.is_cr      = (i_rx_byte == ulaq_pkg::CH_CR);
        o_sts.is_lf      = (i_rx_byte == ulaq_pkg::CH_LF);
        o_sts.ovf        = r_ovf;
        o_sts.line_full  = (r_cur_len == ulaq_pkg::t_idx'(ulaq_pkg::LINE_MAX - 1));
        o_sts.can_commit = (r_cur_len != '0) && !r_ovf
                           && (r_held < ulaq_pkg::t_cnt'(ulaq_pkg::QUEUE_DEPTH));
        o_sts.read_ok    = (i_read_limit >= ulaq_pkg::MIN_READ_LIMIT) && (r_held != '0);
        o_sts.copy_last  = (r_cidx == r_cur_len - 1'b1);
        o_sts.byte_ok    = (r_idx < r_nlim) && (r_slot_q != '0);
        o_sts.pend_vld   = r_pend_vld;
        o_sts.out_free   = out_free;
    end

    // Next values of the control state
    always_comb begin
        n_cur_len  = r_cur_len;
        n_ovf      = r_ovf;
        n_wslot    = r_wslot;
        n_rslot    = r_rslot;
        n_held     = r_held;
        n_cidx     = r_cidx;
        n_cp_vld   = i_cmd.copy_step;
        n_rbase    = r_rbase;
        n_idx      = r_idx;
        n_nlim     = r_nlim;
        n_pend_vld = r_pend_vld;
        n_out_vld  = r_out_vld;
        if (i_cmd.rx_store) begin
            n_cur_len = r_cur_len + 1'b1;
        end
        if (i_cmd.rx_ovf) begin
            n_ovf = 1'b1;
        end
        if (i_cmd.line_clear || i_cmd.commit) begin
            n_cur_len = '0;
            n_ovf     = 1'b0;
        end
        if (i_cmd.copy_start) begin
            n_cidx = '0;
        end
        if (i_cmd.copy_step) begin
            n_cidx = r_cidx + 1'b1;
        end
        if (i_cmd.commit) begin
            n_wslot = slot_next(r_wslot);
            n_held  = r_held + 1'b1;
        end
        // Pop the oldest line up front; its slot is held in r_rbase
        if (i_cmd.rd_start) begin
            n_rbase    = r_rslot;
            n_nlim     = nlim_calc;
            n_idx      = '0;
            n_pend_vld = 1'b0;
            n_rslot    = slot_next(r_rslot);
            n_held     = r_held - 1'b1;
        end
        if (i_cmd.rd_advance) begin
            n_idx      = r_idx + 1'b1;
            n_pend_vld = 1'b1;
        end
        if (i_cmd.out_sel != ulaq_pkg::OUT_NONE) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_len  <= '0;
            r_ovf      <= 1'b0;
            r_wslot    <= '0;
            r_rslot    <= '0;
            r_held     <= '0;
            r_cidx     <= '0;
            r_cp_vld   <= 1'b0;
            r_rbase    <= '0;
            r_idx      <= '0;
            r_nlim     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cur_len  <= n_cur_len;
            r_ovf      <= n_ovf;
            r_wslot    <= n_wslot;
            r_rslot    <= n_rslot;
            r_held     <= n_held;
            r_cidx     <= n_cidx;
            r_cp_vld   <= n_cp_vld;
            r_rbase    <= n_rbase;
            r_idx      <= n_idx;
            r_nlim     <= n_nlim;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Line assembly buffer: append on store, read one byte a cycle on copy
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_store) begin
            cur_mem[r_cur_len] <= i_rx_byte;
        end
        if (i_cmd.copy_step) begin
            r_cur_q  <= cur_mem[r_cidx];
            r_cp_idx <= r_cidx;
        end
    end

    // Slot memory: copy writes land in the cycle after the buffer read
    always_ff @(posedge i_clk) begin
        if (r_cp_vld) begin
            slot_mem[{r_wslot, r_cp_idx}] <= r_cur_q;
        end
        if (i_cmd.rd_fetch) begin
            r_slot_q <= slot_mem[{r_rbase, r_idx}];
        end
    end

    // Slot lengths and read-out lookahead byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_slen[r_wslot] <= r_cur_len;
        end
        if (i_cmd.rd_advance) begin
            r_pend <= r_slot_q;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.out_sel)
            ulaq_pkg::OUT_REFUSE: begin
                r_out_has  <= 1'b0;
                r_out_bv   <= 1'b0;
                r_out_byte <= '0;
                r_out_last <= 1'b1;
            end
            ulaq_pkg::OUT_MID: begin
                r_out_has  <= 1'b1;
                r_out_bv   <= 1'b1;
                r_out_byte <= r_pend;
                r_out_last <= 1'b0;
            end
            ulaq_pkg::OUT_END: begin
                r_out_has  <= 1'b1;
                r_out_bv   <= r_pend_vld;
                r_out_byte <= r_pend_vld ? r_pend : '0;
                r_out_last <= 1'b1;
            end
            default: begin
                r_out_has <= r_out_has;
            end
        endcase
    end

    assign o_out_valid  = r_out_vld;
    assign o_has_line   = r_out_has;
    assign o_byte_valid = r_out_bv;
    assign o_data_byte  = r_out_byte;
    assign o_last       = r_out_last;

    // Checks
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= ulaq_pkg::QUEUE_DEPTH)
        else $error("line count above ring depth");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur_len) <= ulaq_pkg::LINE_MAX - 1)
        else $error("assembled line longer than buffer");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_sel != ulaq_pkg::OUT_NONE) |-> out_free)
        else $error("result beat loaded over a waiting beat");

    a_commit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (32'(r_held) == 32'($past(r_held)) + 1))
        else $error("commit did not add one line");

endmodule

// ----- hdl/uart_line_assembler_queue_core.sv -----
// ----------------------------------------------------------------------------
// uart_line_assembler_queue_core
// Line-buffered receive queue: gathers received bytes into lines and hands
// out whole lines on read requests.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. A received byte other than line feed
// is handled in the idle state. A line feed that commits a line holds off
// the next beat while the line is copied byte by byte from the assembly
// buffer into the single-port slot memory; a line feed that drops the line
// is handled in the idle state. A read request pops the oldest line and
// emits one result beat per byte; each byte goes through a slot memory read,
// then a zero/limit check, and the read waits while the output register is full.
// A refused read (limit below 2 or empty ring) gives a single beat. Result
// beats leave through an output register, so the input is taken again while
// the final beat still waits. There is no clearing pass after reset.
module uart_line_assembler_queue_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ulaq_in_if.sink      i_in,
    ulaq_out_if.source   o_out
);

    ulaq_pkg::t_cmd cmd;
    ulaq_pkg::t_sts sts;

    ulaq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ulaq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_in.req_type),
        .i_rx_byte    (i_in.rx_byte),
        .i_read_limit (i_in.read_limit),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_has_line   (o_out.has_line),
        .o_byte_valid (o_out.byte_valid),
        .o_data_byte  (o_out.data_byte),
        .o_last       (o_out.last)
    );

endmodule
